### rtl/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg
// shared types, widths, register indexes and helpers of the time series
// resampler
// ----------------------------------------------------------------------------
package tsr_pkg;

    // default sizing handed to the top level
    localparam int FIELD_COUNT_DEF = 4;
    localparam int MAX_BURST_DEF   = 64;

    // fixed widths
    localparam int SLOT_COUNT = 4;
    localparam int VAL_W      = 32;
    localparam int TIME_W     = 32;
    localparam int STEP_W     = 40;
    localparam int CNT_W      = 16;
    localparam int GRID_W     = 56;
    localparam int T16_W      = 48;
    localparam int QUOT_W     = 32;
    localparam int DIV_LOW_W  = 64;
    localparam int DIV_CNT_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd2;

    // register reset values
    localparam logic [STEP_W-1:0] STEP_RESET   = 40'd65536;
    localparam logic [CNT_W-1:0]  SCNT_RESET   = 16'd0;
    localparam logic [CNT_W-1:0]  OUTCNT_RESET = 16'd1000;

    // divider iteration counts
    localparam logic [DIV_CNT_W-1:0] RATIO_ITERS = 7'd32;
    localparam logic [DIV_CNT_W-1:0] DROP_ITERS  = 7'd48;

    typedef struct packed {
        logic        [TIME_W-1:0] in_time;
        logic signed [VAL_W-1:0]  value_0;
        logic signed [VAL_W-1:0]  value_1;
        logic signed [VAL_W-1:0]  value_2;
        logic signed [VAL_W-1:0]  value_3;
        logic                     first_sample;
    } t_tsr_in;

    typedef struct packed {
        logic        [TIME_W-1:0] out_time;
        logic signed [VAL_W-1:0]  out_value_0;
        logic signed [VAL_W-1:0]  out_value_1;
        logic signed [VAL_W-1:0]  out_value_2;
        logic signed [VAL_W-1:0]  out_value_3;
        logic                     last_of_run;
        logic                     overflow;
    } t_tsr_out;

    // lane sequencing
    typedef struct packed {
        logic load;
        logic mul;
        logic round;
        logic commit;
    } t_tsr_lane_ctl;

    // result request toward the output register
    typedef struct packed {
        logic              load;
        logic              use_interp;
        logic [TIME_W-1:0] time_val;
        logic              last;
        logic              ovf;
    } t_tsr_emit;

    // divider start request
    typedef struct packed {
        logic                 start;
        logic [STEP_W-1:0]    rem_init;
        logic [DIV_LOW_W-1:0] low;
        logic [DIV_CNT_W-1:0] iters;
        logic [STEP_W-1:0]    divisor;
    } t_tsr_div_req;

    // grid advance, saturating at the top of the grid range
    function automatic logic [GRID_W-1:0] sat_add56(input logic [GRID_W-1:0] a,
                                                    input logic [STEP_W-1:0] b);
        logic [GRID_W:0] s;
        s = {1'b0, a} + (GRID_W+1)'(b);
        return s[GRID_W] ? {GRID_W{1'b1}} : s[GRID_W-1:0];
    endfunction

endpackage

### rtl/time_series_resampler_core.sv
// ----------------------------------------------------------------------------
// time_series_resampler_core
// resamples a stream of timed samples onto a fixed grid by decimation or
// linear interpolation
// ----------------------------------------------------------------------------
// Input requests (i_in_valid / o_in_stall) carry one sample; output requests
// (o_out_valid / i_out_stall) carry one grid result each, up to MAX_BURST per
// sample, the last one flagged last_of_run. Registers are to be written while
// the block is idle, through i_cfg_we / i_cfg_index / i_cfg_data; the block
// itself does not enforce it. One sample is worked on at a time. A first or
// decimating sample emits at most one result; an interpolating sample flags
// overflow, then per grid point the one bit per cycle divider forms the ratio
// (skipped when zero), the lanes multiply and round and the result is emitted;
// excess points are skipped by another division. The field lanes work in
// parallel on the ratio. An output register decouples the receiver: a stalled
// result holds, and the sequencer waits only when the next result finds the
// register still occupied. Synchronous reset clears the registers to their
// defaults, the grid and the run state; no result is pending after reset.
// ----------------------------------------------------------------------------
module time_series_resampler_core #(
    parameter int FIELD_COUNT = tsr_pkg::FIELD_COUNT_DEF,
    parameter int MAX_BURST   = tsr_pkg::MAX_BURST_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  tsr_pkg::t_tsr_in                     i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output tsr_pkg::t_tsr_out                    o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [tsr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tsr_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    localparam int BURST_W = $clog2(MAX_BURST + 1);
    localparam int SPAN_W  = tsr_pkg::STEP_W + BURST_W;
    localparam int GW      = tsr_pkg::GRID_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_SPAN   = 4'd2;
    localparam logic [3:0] S_OVF    = 4'd3;
    localparam logic [3:0] S_POINT  = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_DROP   = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_ROUND  = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;
    localparam logic [3:0] S_SAMPLE = 4'd10;
    localparam logic [3:0] S_COMMIT = 4'd11;

    logic [3:0]                          r_state, n_state;
    logic [tsr_pkg::STEP_W-1:0]          r_step, n_step;
    logic [tsr_pkg::CNT_W-1:0]           r_scnt, n_scnt;
    logic [tsr_pkg::CNT_W-1:0]           r_outcnt, n_outcnt;
    logic [tsr_pkg::TIME_W-1:0]          r_prev_time, n_prev_time;
    logic [GW-1:0]                       r_grid, n_grid;
    logic [tsr_pkg::CNT_W-1:0]           r_emitted, n_emitted;
    logic                                r_started, n_started;
    logic                                r_ovf, n_ovf;
    logic [BURST_W-1:0]                  r_n, n_n;
    tsr_pkg::t_tsr_in                    r_item, n_item;
    logic [SPAN_W-1:0]                   r_span, n_span;
    logic [tsr_pkg::QUOT_W-1:0]          r_ratio, n_ratio;

    tsr_pkg::t_tsr_lane_ctl              lane_ctl;
    tsr_pkg::t_tsr_emit                  emit;
    tsr_pkg::t_tsr_div_req               div_req;
    logic                                div_done;
    logic [tsr_pkg::QUOT_W-1:0]          div_quot;
    logic [tsr_pkg::STEP_W-1:0]          div_rem;
    logic                                out_free;

    logic [tsr_pkg::T16_W-1:0]           t16;
    logic [GW-1:0]                       t16_g;
    logic [GW-1:0]                       p16_g;
    logic [GW-1:0]                       grid_next;
    logic [GW-1:0]                       num;
    logic [tsr_pkg::TIME_W-1:0]          dt;
    logic [GW-1:0]                       gap;
    logic [GW:0]                         ovf_sum;
    logic                                more;
    logic                                next_more;

    logic [tsr_pkg::SLOT_COUNT-1:0][tsr_pkg::VAL_W-1:0] cur_vals;
    logic [tsr_pkg::SLOT_COUNT-1:0][tsr_pkg::VAL_W-1:0] lane_vals;

    // sample and grid arithmetic shared by the states
    assign t16       = {r_item.in_time, 16'h0000};
    assign t16_g     = GW'(t16);
    assign p16_g     = GW'({r_prev_time, 16'h0000});
    assign grid_next = tsr_pkg::sat_add56(r_grid, r_step);
    assign num       = (r_grid > p16_g) ? r_grid - p16_g : '0;
    assign dt        = r_item.in_time - r_prev_time;
    assign gap       = t16_g - r_grid;
    assign ovf_sum   = {1'b0, r_grid} + (GW+1)'(r_span);
    assign more      = (r_grid < t16_g) && (r_emitted < r_outcnt);
    assign next_more = (grid_next < t16_g)
                     && ((17'(r_emitted) + 17'd1) < 17'(r_outcnt))
                     && (((BURST_W+1)'(r_n) + 1'b1) < (BURST_W+1)'(MAX_BURST));

    // zero fill for fields beyond the configured count
    assign cur_vals[0] = (FIELD_COUNT > 0) ? r_item.value_0 : '0;
    assign cur_vals[1] = (FIELD_COUNT > 1) ? r_item.value_1 : '0;
    assign cur_vals[2] = (FIELD_COUNT > 2) ? r_item.value_2 : '0;
    assign cur_vals[3] = (FIELD_COUNT > 3) ? r_item.value_3 : '0;

    assign o_in_stall = (r_state != S_IDLE);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_scnt      = r_scnt;
        n_outcnt    = r_outcnt;
        n_prev_time = r_prev_time;
        n_grid      = r_grid;
        n_emitted   = r_emitted;
        n_started   = r_started;
        n_ovf       = r_ovf;
        n_n         = r_n;
        n_item      = r_item;
        n_span      = r_span;
        n_ratio     = r_ratio;
        lane_ctl    = '0;
        emit        = '0;
        div_req     = '0;

        // register writes
        if (i_cfg_we) begin
            case (i_cfg_index)
                tsr_pkg::CFG_STEP_SIZE:    n_step   = i_cfg_data[tsr_pkg::STEP_W-1:0];
                tsr_pkg::CFG_SAMPLE_COUNT: n_scnt   = i_cfg_data[tsr_pkg::CNT_W-1:0];
                tsr_pkg::CFG_OUTPUT_COUNT: n_outcnt = i_cfg_data[tsr_pkg::CNT_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                lane_ctl.load = 1'b1;
                if (r_item.first_sample) begin
                    n_started = 1'b1;
                    n_grid    = tsr_pkg::sat_add56(t16_g, r_step);
                    if (r_outcnt != '0) begin
                        n_emitted = 16'd1;
                        n_state   = S_SAMPLE;
                    end else begin
                        n_emitted = '0;
                        n_state   = S_COMMIT;
                    end
                end else if (!r_started) begin
                    n_state = S_IDLE;
                end else if (r_scnt > r_outcnt) begin
                    // decimate
                    if ((t16_g >= r_grid) && (r_emitted < r_outcnt)) begin
                        n_grid    = grid_next;
                        n_emitted = r_emitted + 1'b1;
                        n_state   = S_SAMPLE;
                    end else begin
                        n_state = S_COMMIT;
                    end
                end else begin
                    n_state = S_SPAN;
                end
            end
            S_SPAN: begin
                n_span  = SPAN_W'(r_step) * SPAN_W'(MAX_BURST);
                n_n     = '0;
                n_state = S_OVF;
            end
            S_OVF: begin
                // points remain after a full burst
                n_ovf   = (ovf_sum < (GW+1)'(t16))
                        && ((17'(r_emitted) + 17'(MAX_BURST)) < 17'(r_outcnt));
                n_state = S_POINT;
            end
            S_POINT: begin
                if (!more) begin
                    n_state = S_COMMIT;
                end else if (r_n == BURST_W'(MAX_BURST)) begin
                    // skip to the first grid point at or after the sample
                    if (r_step == '0) begin
                        n_grid  = t16_g;
                        n_state = S_COMMIT;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.rem_init = '0;
                        div_req.low      = {gap[tsr_pkg::T16_W-1:0], 16'h0000};
                        div_req.iters    = tsr_pkg::DROP_ITERS;
                        div_req.divisor  = r_step;
                        n_state          = S_DROP;
                    end
                end else if (num == '0) begin
                    n_ratio = '0;
                    n_state = S_MUL;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = tsr_pkg::STEP_W'(num[tsr_pkg::T16_W-1:16]);
                    div_req.low      = {num[15:0], 48'h0};
                    div_req.iters    = tsr_pkg::RATIO_ITERS;
                    div_req.divisor  = tsr_pkg::STEP_W'(dt);
                    n_state          = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_ratio = div_quot;
                    n_state = S_MUL;
                end
            end
            S_DROP: begin
                if (div_done) begin
                    n_grid  = t16_g + ((div_rem != '0) ? GW'(r_step - div_rem) : '0);
                    n_state = S_COMMIT;
                end
            end
            S_MUL: begin
                lane_ctl.mul = 1'b1;
                n_state      = S_ROUND;
            end
            S_ROUND: begin
                lane_ctl.round = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    emit.load       = 1'b1;
                    emit.use_interp = 1'b1;
                    emit.time_val   = r_grid[tsr_pkg::T16_W-1:16];
                    emit.last       = !next_more;
                    emit.ovf        = r_ovf;
                    n_grid          = grid_next;
                    n_emitted       = r_emitted + 1'b1;
                    n_n             = r_n + 1'b1;
                    n_state         = S_POINT;
                end
            end
            S_SAMPLE: begin
                if (out_free) begin
                    emit.load       = 1'b1;
                    emit.use_interp = 1'b0;
                    emit.time_val   = r_item.in_time;
                    emit.last       = 1'b1;
                    emit.ovf        = 1'b0;
                    n_state         = S_COMMIT;
                end
            end
            S_COMMIT: begin
                lane_ctl.commit = 1'b1;
                n_prev_time     = r_item.in_time;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= tsr_pkg::STEP_RESET;
            r_scnt      <= tsr_pkg::SCNT_RESET;
            r_outcnt    <= tsr_pkg::OUTCNT_RESET;
            r_prev_time <= '0;
            r_grid      <= '0;
            r_emitted   <= '0;
            r_started   <= 1'b0;
            r_ovf       <= 1'b0;
            r_n         <= '0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_scnt      <= n_scnt;
            r_outcnt    <= n_outcnt;
            r_prev_time <= n_prev_time;
            r_grid      <= n_grid;
            r_emitted   <= n_emitted;
            r_started   <= n_started;
            r_ovf       <= n_ovf;
            r_n         <= n_n;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_span  <= n_span;
        r_ratio <= n_ratio;
    end

    // shared divider
    tsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    // one lane per value field
    for (genvar g = 0; g < tsr_pkg::SLOT_COUNT; g++) begin : g_lane
        if (g < FIELD_COUNT) begin : g_on
            tsr_lane u_lane (
                .i_clk   (i_clk),
                .i_ctl   (lane_ctl),
                .i_cur   (cur_vals[g]),
                .i_ratio (r_ratio),
                .o_val   (lane_vals[g])
            );
        end else begin : g_off
            assign lane_vals[g] = '0;
        end
    end

    // result assembly and output register
    tsr_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_emit      (emit),
        .i_lane_val  (lane_vals),
        .i_cur       (cur_vals),
        .i_out_stall (i_out_stall),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/tsr_div.sv
// ----------------------------------------------------------------------------
// tsr_div
// restoring divider, one quotient bit per cycle, shared by the ratio and
// the grid skip computations
// ----------------------------------------------------------------------------
module tsr_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tsr_pkg::t_tsr_div_req               i_req,
    output logic                                o_done,
    output logic [tsr_pkg::QUOT_W-1:0]          o_quot,
    output logic [tsr_pkg::STEP_W-1:0]          o_rem
);
    logic                                r_busy;
    logic [tsr_pkg::DIV_CNT_W-1:0]       r_cnt;
    logic [tsr_pkg::STEP_W-1:0]          r_rem;
    logic [tsr_pkg::DIV_LOW_W-1:0]       r_low;
    logic [tsr_pkg::QUOT_W-1:0]          r_quot;
    logic [tsr_pkg::STEP_W-1:0]          r_div;
    logic [tsr_pkg::STEP_W+1:0]          trial;

    // trial subtract of the shifted partial remainder
    assign trial = {1'b0, r_rem, r_low[tsr_pkg::DIV_LOW_W-1]} - {2'b00, r_div};

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.iters;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.rem_init;
            r_low  <= i_req.low;
            r_div  <= i_req.divisor;
            r_quot <= '0;
        end else if (r_busy && (r_cnt != '0)) begin
            if (!trial[tsr_pkg::STEP_W+1]) begin
                r_rem  <= trial[tsr_pkg::STEP_W-1:0];
                r_quot <= {r_quot[tsr_pkg::QUOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= {r_rem[tsr_pkg::STEP_W-2:0], r_low[tsr_pkg::DIV_LOW_W-1]};
                r_quot <= {r_quot[tsr_pkg::QUOT_W-2:0], 1'b0};
            end
            r_low <= {r_low[tsr_pkg::DIV_LOW_W-2:0], 1'b0};
        end
    end

endmodule

### rtl/tsr_lane.sv
// ----------------------------------------------------------------------------
// tsr_lane
// one value field: keeps the previous sample and interpolates toward the
// current one with a shared ratio
// ----------------------------------------------------------------------------
module tsr_lane (
    input  logic                               i_clk,
    input  tsr_pkg::t_tsr_lane_ctl             i_ctl,
    input  logic signed [tsr_pkg::VAL_W-1:0]   i_cur,
    input  logic [tsr_pkg::QUOT_W-1:0]         i_ratio,
    output logic signed [tsr_pkg::VAL_W-1:0]   o_val
);
    logic signed [tsr_pkg::VAL_W-1:0] r_prev;
    logic                             r_neg;
    logic [tsr_pkg::VAL_W-1:0]        r_mag;
    logic [2*tsr_pkg::VAL_W-1:0]      r_prod;
    logic signed [tsr_pkg::VAL_W-1:0] r_val;
    logic [tsr_pkg::VAL_W:0]          diff;
    logic [tsr_pkg::VAL_W:0]          diff_neg;
    logic [2*tsr_pkg::VAL_W-1:0]      rnd;
    logic [tsr_pkg::VAL_W-1:0]        q;

    // signed difference, one bit wider than the values
    assign diff     = {i_cur[tsr_pkg::VAL_W-1], i_cur} - {r_prev[tsr_pkg::VAL_W-1], r_prev};
    assign diff_neg = -diff;

    // round to nearest, ties away from the previous value
    assign rnd = r_prod + 64'h0000_0000_8000_0000;
    assign q   = rnd[2*tsr_pkg::VAL_W-1:tsr_pkg::VAL_W];

    assign o_val = r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_neg <= diff[tsr_pkg::VAL_W];
            r_mag <= diff[tsr_pkg::VAL_W] ? diff_neg[tsr_pkg::VAL_W-1:0]
                                          : diff[tsr_pkg::VAL_W-1:0];
        end
        if (i_ctl.mul) begin
            r_prod <= 64'(r_mag) * 64'(i_ratio);
        end
        if (i_ctl.round) begin
            r_val <= r_neg ? r_prev - $signed(q) : r_prev + $signed(q);
        end
        if (i_ctl.commit) begin
            r_prev <= i_cur;
        end
    end

endmodule

### rtl/tsr_merge.sv
// ----------------------------------------------------------------------------
// tsr_merge
// combines the lane results or the raw sample into one result and holds it
// in the output register
// ----------------------------------------------------------------------------
module tsr_merge (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  tsr_pkg::t_tsr_emit                                  i_emit,
    input  logic [tsr_pkg::SLOT_COUNT-1:0][tsr_pkg::VAL_W-1:0]  i_lane_val,
    input  logic [tsr_pkg::SLOT_COUNT-1:0][tsr_pkg::VAL_W-1:0]  i_cur,
    input  logic                                                i_out_stall,
    output logic                                                o_free,
    output logic                                                o_out_valid,
    output tsr_pkg::t_tsr_out                                   o_out_data
);
    logic                                               r_valid;
    tsr_pkg::t_tsr_out                                  r_data;
    logic [tsr_pkg::SLOT_COUNT-1:0][tsr_pkg::VAL_W-1:0] sel;

    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    // pick interpolated or sample values
    assign sel = i_emit.use_interp ? i_lane_val : i_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_emit.load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.load) begin
            r_data.out_time    <= i_emit.time_val;
            r_data.out_value_0 <= sel[0];
            r_data.out_value_1 <= sel[1];
            r_data.out_value_2 <= sel[2];
            r_data.out_value_3 <= sel[3];
            r_data.last_of_run <= i_emit.last;
            r_data.overflow    <= i_emit.ovf;
        end
    end

endmodule

### rtl/tsr_checker.sv
// ----------------------------------------------------------------------------
// tsr_checker
// port level checks of the time series resampler, bound to the top level
// ----------------------------------------------------------------------------
module tsr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input tsr_pkg::t_tsr_out               o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output request changed while stalled");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // reset leaves the block ready for a request
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // one request at a time: an accepted request blocks the next cycle
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request accepted while busy");

endmodule

bind time_series_resampler_core tsr_checker u_tsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
